// File: hdl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg
// Shared widths, request codes and status codes for the bounded ordered list.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int ST_W  = 3;
  localparam int LEN_W = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP_FWD  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DUMP_BACK = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 3'd2;
  localparam logic [ST_W-1:0] ST_BEYOND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd4;

endpackage

// File: hdl/bol_ram.sv
// ----------------------------------------------------------------------------
// bol_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bol_ram #(
  parameter int DEPTH = bol_pkg::CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DW    = bol_pkg::VAL_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bounded_ordered_list.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of signed 32-bit values, at most CAPACITY entries, in memory.
// ----------------------------------------------------------------------------
// Requests are append at the tail, delete at a 1-based position, dump front to
// back or back to front, and clear. Entries sit packed in one synchronous
// memory, in order, from address 0 up to the entry count. One request is
// handled at a time. Append, clear, rejected requests and deletion of the
// tail entry finish in the cycle the request beat is taken. Any other delete
// closes the gap by moving one entry per cycle through the memory read port.
// A dump reads its first entry when the request is taken, then sends one
// result beat per cycle while the result side does not stall. The result
// beat sits in an output register, so the next request can be taken in the
// same cycle as a single-beat result is collected; while a result beat is
// held by a stall, the request side stalls too. Every request ends with a
// beat carrying last = 1; an empty dump gives one beat with the list-empty
// status.
module bounded_ordered_list #(
  parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [bol_pkg::REQ_W-1:0]        req_type,
  input  logic signed [bol_pkg::VAL_W-1:0] value,
  input  logic [bol_pkg::POS_W-1:0]        position,
  // result channel
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [bol_pkg::ST_W-1:0]         status,
  output logic signed [bol_pkg::VAL_W-1:0] item_value,
  output logic [bol_pkg::LEN_W-1:0]        length,
  output logic                             last
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CW1 = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,   // waiting for a request
    S_DEL  = 4'b0010,   // shifting entries down over the deleted one
    S_FIN  = 4'b0100,   // delete done, result beat pending
    S_DUMP = 4'b1000    // streaming entries out
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] count, count_next;   // entries held
  logic [AW-1:0] idx, idx_next;       // shift write index / dump address
  logic [CW-1:0] sent, sent_next;     // dump beats sent so far
  logic          back, back_next;     // dump direction

  // memory port
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [bol_pkg::VAL_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [bol_pkg::VAL_W-1:0] ram_rdata;

  // result beat being loaded
  logic                             out_free;
  logic                             out_load;
  logic [bol_pkg::ST_W-1:0]         o_status;
  logic signed [bol_pkg::VAL_W-1:0] o_value;
  logic [bol_pkg::LEN_W-1:0]        o_len;
  logic                             o_last;

  logic          accept;
  logic          dump_end;
  logic [AW-1:0] dump_first;
  logic [AW-1:0] dump_step;

  bol_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (bol_pkg::VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register is free when empty or being taken this cycle
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;

  assign dump_end   = ((sent + CW'(1)) == count);
  assign dump_first = (req_type == bol_pkg::REQ_DUMP_BACK) ? AW'(count - CW'(1)) : '0;
  assign dump_step  = back ? (idx - AW'(1)) : (idx + AW'(1));

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    sent_next  = sent;
    back_next  = back;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = idx;
    out_load   = 1'b0;
    o_status   = bol_pkg::ST_OK;
    o_value    = '0;
    o_len      = bol_pkg::LEN_W'(count);
    o_last     = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            bol_pkg::REQ_APPEND: begin
              out_load = 1'b1;
              if (count >= CW'(CAPACITY)) begin
                o_status = bol_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(count);
                ram_wdata  = value;
                count_next = count + CW'(1);
                o_len      = bol_pkg::LEN_W'(count + CW'(1));
              end
            end
            bol_pkg::REQ_DELETE: begin
              if (count == '0) begin
                out_load = 1'b1;
                o_status = bol_pkg::ST_EMPTY;
              end else if (position == '0) begin
                out_load = 1'b1;
                o_status = bol_pkg::ST_BADPOS;
              end else if (position > bol_pkg::LEN_W'(count)) begin
                out_load = 1'b1;
                o_status = bol_pkg::ST_BEYOND;
              end else if (position == bol_pkg::LEN_W'(count)) begin
                // tail entry: nothing to move
                out_load   = 1'b1;
                count_next = count - CW'(1);
                o_len      = bol_pkg::LEN_W'(count - CW'(1));
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(position);
                idx_next   = AW'(position - bol_pkg::POS_W'(1));
                state_next = S_DEL;
              end
            end
            bol_pkg::REQ_DUMP_FWD, bol_pkg::REQ_DUMP_BACK: begin
              if (count == '0) begin
                out_load = 1'b1;
                o_status = bol_pkg::ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = dump_first;
                idx_next   = dump_first;
                sent_next  = '0;
                back_next  = (req_type == bol_pkg::REQ_DUMP_BACK);
                state_next = S_DUMP;
              end
            end
            bol_pkg::REQ_CLEAR: begin
              out_load = 1'b1;
              o_len    = '0;
              if (count == '0) begin
                o_status = bol_pkg::ST_EMPTY;
              end else begin
                count_next = '0;
              end
            end
            default: begin
              out_load = 1'b1;
              o_status = bol_pkg::ST_BADPOS;
            end
          endcase
        end
      end
      S_DEL: begin
        // entry idx+1 is on the read port: move it down to idx
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if ((CW1'(idx) + CW1'(2)) < CW1'(count)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(CW1'(idx) + CW1'(2));
          idx_next  = idx + AW'(1);
        end else begin
          count_next = count - CW'(1);
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load = 1'b1;
          o_value  = ram_rdata;
          o_last   = dump_end;
          if (dump_end) begin
            state_next = S_IDLE;
          end else begin
            sent_next = sent + CW'(1);
            idx_next  = dump_step;
            ram_re    = 1'b1;
            ram_raddr = dump_step;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    sent <= sent_next;
    back <= back_next;
    if (out_load) begin
      status     <= o_status;
      item_value <= o_value;
      length     <= o_len;
      last       <= o_last;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CW'(ram_waddr) <= count))
    else $error("memory write outside the packed entries");

  a_no_load_over_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !out_load)
    else $error("result beat overwritten while stalled");

  a_del_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEL) |=> (state == S_DEL || state == S_FIN))
    else $error("shift left without its result");

  a_mid_dump_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !last) |-> (status == bol_pkg::ST_OK))
    else $error("non-final beat with error status");
`endif

endmodule
